// ===== hdl/rectangle_subtract_split_defines.svh =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_SUBTRACT_SPLIT_DEFINES_SVH
`define RECTANGLE_SUBTRACT_SPLIT_DEFINES_SVH

// Same-cycle implication.
`define RSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: package
// Shared constants, codes and inter-stage control structs.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int CoordWidthDef = 16;

    // Edge positions inside a packed rectangle
    localparam int EdgeL = 0;
    localparam int EdgeT = 1;
    localparam int EdgeR = 2;
    localparam int EdgeB = 3;

    // Outcome codes
    localparam logic [2:0] OutSplit    = 3'd0;
    localparam logic [2:0] OutSrcEmpty = 3'd1;
    localparam logic [2:0] OutCutEmpty = 3'd2;
    localparam logic [2:0] OutSame     = 3'd3;
    localparam logic [2:0] OutDisjoint = 3'd4;
    localparam logic [2:0] OutCovered  = 3'd5;

    // Piece slots in emission order
    localparam logic [2:0] SlotLT = 3'd0;
    localparam logic [2:0] SlotLB = 3'd1;
    localparam logic [2:0] SlotLM = 3'd2;
    localparam logic [2:0] SlotRT = 3'd3;
    localparam logic [2:0] SlotRB = 3'd4;
    localparam logic [2:0] SlotRM = 3'd5;
    localparam logic [2:0] SlotTM = 3'd6;
    localparam logic [2:0] SlotBM = 3'd7;

    localparam int NumSlots = 8;

    typedef struct packed {
        logic src_empty;
        logic cut_empty;
        logic same;
        logic disjoint;
        logic covered;
        logic hl;
        logic hr;
        logic ht;
        logic hb;
    } t_cmp;

    typedef struct packed {
        logic [2:0]          outcome;
        logic                pass;
        logic [NumSlots-1:0] mask;
    } t_plan;

endpackage

// ===== hdl/rss_in_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: input channel
// Source and cut rectangles with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rss_in_if #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] src_left;
    logic signed [COORD_WIDTH-1:0] src_top;
    logic signed [COORD_WIDTH-1:0] src_right;
    logic signed [COORD_WIDTH-1:0] src_bottom;
    logic signed [COORD_WIDTH-1:0] cut_left;
    logic signed [COORD_WIDTH-1:0] cut_top;
    logic signed [COORD_WIDTH-1:0] cut_right;
    logic signed [COORD_WIDTH-1:0] cut_bottom;

    modport source (
        output valid, src_left, src_top, src_right, src_bottom,
               cut_left, cut_top, cut_right, cut_bottom,
        input  ready
    );
    modport sink (
        input  valid, src_left, src_top, src_right, src_bottom,
               cut_left, cut_top, cut_right, cut_bottom,
        output ready
    );
endinterface

// ===== hdl/rss_out_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: result channel
// One remaining piece or a status item per handshake.
// ----------------------------------------------------------------------------
interface rss_out_if #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] piece_left;
    logic signed [COORD_WIDTH-1:0] piece_top;
    logic signed [COORD_WIDTH-1:0] piece_right;
    logic signed [COORD_WIDTH-1:0] piece_bottom;
    logic                          piece_valid;
    logic [2:0]                    outcome;
    logic                          last_piece;

    modport source (
        output valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, outcome, last_piece,
        input  ready
    );
    modport sink (
        input  valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, outcome, last_piece,
        output ready
    );
endinterface

// ===== hdl/rss_cmp.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: compare stage
// Registers the edges and every edge comparison the later stages need.
// ----------------------------------------------------------------------------
module rss_cmp #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rss_in_if.sink                    i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [3:0][COORD_WIDTH-1:0] o_src,
    output logic [3:0][COORD_WIDTH-1:0] o_cut,
    output rss_pkg::t_cmp             o_flags
);
    logic                          r_valid;
    logic [3:0][COORD_WIDTH-1:0]   r_src;
    logic [3:0][COORD_WIDTH-1:0]   r_cut;
    rss_pkg::t_cmp                 r_flags;
    rss_pkg::t_cmp                 n_flags;
    logic                          advance;

    logic signed [COORD_WIDTH-1:0] sl, st, sr, sb, cl, ct, cr, cb;

    assign sl = i_item.src_left;
    assign st = i_item.src_top;
    assign sr = i_item.src_right;
    assign sb = i_item.src_bottom;
    assign cl = i_item.cut_left;
    assign ct = i_item.cut_top;
    assign cr = i_item.cut_right;
    assign cb = i_item.cut_bottom;

    assign advance      = !r_valid || i_ready;
    assign i_item.ready = advance;

    always_comb begin
        n_flags.src_empty = (sr <= sl) || (sb <= st);
        n_flags.cut_empty = (cr <= cl) || (cb <= ct);
        n_flags.same      = (cl == sl) && (ct == st) && (cr == sr) && (cb == sb);
        n_flags.disjoint  = (cl >= sr) || (cr <= sl) || (ct >= sb) || (cb <= st);
        n_flags.covered   = (sl >= cl) && (sr <= cr) && (st >= ct) && (sb <= cb);
        n_flags.hl        = (cl > sl) && (cl < sr);
        n_flags.hr        = (cr < sr) && (cr > sl);
        n_flags.ht        = (ct > st) && (ct < sb);
        n_flags.hb        = (cb < sb) && (cb > st);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_item.valid;
        end
        if (advance) begin
            r_src   <= {sb, sr, st, sl};
            r_cut   <= {cb, cr, ct, cl};
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_src   = r_src;
    assign o_cut   = r_cut;
    assign o_flags = r_flags;
endmodule

// ===== hdl/rss_plan.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: plan stage
// Picks the outcome, the piece mask and the middle band edges.
// ----------------------------------------------------------------------------
module rss_plan #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0][COORD_WIDTH-1:0] i_src,
    input  logic [3:0][COORD_WIDTH-1:0] i_cut,
    input  rss_pkg::t_cmp               i_flags,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0][COORD_WIDTH-1:0] o_src,
    output logic [3:0][COORD_WIDTH-1:0] o_cut,
    output logic [3:0][COORD_WIDTH-1:0] o_mid,
    output rss_pkg::t_plan              o_plan
);
    logic                        r_valid;
    logic [3:0][COORD_WIDTH-1:0] r_src;
    logic [3:0][COORD_WIDTH-1:0] r_cut;
    logic [3:0][COORD_WIDTH-1:0] r_mid;
    rss_pkg::t_plan              r_plan;
    rss_pkg::t_plan              n_plan;
    logic [3:0][COORD_WIDTH-1:0] n_mid;
    logic [rss_pkg::NumSlots-1:0] split_mask;
    logic                        advance;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    // Slot order: LT LB LM RT RB RM TM BM
    assign split_mask = {i_flags.hb,
                         i_flags.ht,
                         i_flags.hr,
                         i_flags.hr & i_flags.hb,
                         i_flags.hr & i_flags.ht,
                         i_flags.hl,
                         i_flags.hl & i_flags.hb,
                         i_flags.hl & i_flags.ht};

    always_comb begin
        n_plan.outcome = rss_pkg::OutSplit;
        n_plan.pass    = 1'b0;
        n_plan.mask    = rss_pkg::NumSlots'(1);
        if (i_flags.src_empty) begin
            n_plan.outcome = rss_pkg::OutSrcEmpty;
        end else if (i_flags.cut_empty) begin
            n_plan.outcome = rss_pkg::OutCutEmpty;
            n_plan.pass    = 1'b1;
        end else if (i_flags.same) begin
            n_plan.outcome = rss_pkg::OutSame;
        end else if (i_flags.disjoint) begin
            n_plan.outcome = rss_pkg::OutDisjoint;
            n_plan.pass    = 1'b1;
        end else if (i_flags.covered || split_mask == '0) begin
            n_plan.outcome = rss_pkg::OutCovered;
        end else begin
            n_plan.mask = split_mask;
        end

        n_mid[rss_pkg::EdgeL] = i_flags.hl ? i_cut[rss_pkg::EdgeL] : i_src[rss_pkg::EdgeL];
        n_mid[rss_pkg::EdgeR] = i_flags.hr ? i_cut[rss_pkg::EdgeR] : i_src[rss_pkg::EdgeR];
        n_mid[rss_pkg::EdgeT] = i_flags.ht ? i_cut[rss_pkg::EdgeT] : i_src[rss_pkg::EdgeT];
        n_mid[rss_pkg::EdgeB] = i_flags.hb ? i_cut[rss_pkg::EdgeB] : i_src[rss_pkg::EdgeB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
        if (advance) begin
            r_src  <= i_src;
            r_cut  <= i_cut;
            r_mid  <= n_mid;
            r_plan <= n_plan;
        end
    end

    assign o_valid = r_valid;
    assign o_src   = r_src;
    assign o_cut   = r_cut;
    assign o_mid   = r_mid;
    assign o_plan  = r_plan;
endmodule

// ===== hdl/rss_emit.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract split: emit stage
// Walks the piece mask one slot a cycle into the output register, holding while a result waits on ready.
// ----------------------------------------------------------------------------
`include "rectangle_subtract_split_defines.svh"

module rss_emit #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0][COORD_WIDTH-1:0] i_src,
    input  logic [3:0][COORD_WIDTH-1:0] i_cut,
    input  logic [3:0][COORD_WIDTH-1:0] i_mid,
    input  rss_pkg::t_plan              i_plan,
    rss_out_if.source                   o_res
);
    localparam int N = rss_pkg::NumSlots;

    logic                        r_busy;
    logic [N-1:0]                r_mask;
    logic [3:0][COORD_WIDTH-1:0] r_src;
    logic [3:0][COORD_WIDTH-1:0] r_cut;
    logic [3:0][COORD_WIDTH-1:0] r_mid;
    logic [2:0]                  r_outcome;
    logic                        r_pass;

    logic                        r_ov;
    logic [3:0][COORD_WIDTH-1:0] r_piece;
    logic                        r_pvalid;
    logic [2:0]                  r_res_outcome;
    logic                        r_last;

    logic [2:0]                  slot;
    logic [N-1:0]                n_mask;
    logic [3:0][COORD_WIDTH-1:0] n_piece;
    logic                        emit_go;
    logic                        take;
    logic                        load;
    logic                        split;

    // Lowest pending slot goes first
    always_comb begin
        slot = rss_pkg::SlotLT;
        for (int k = N - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                slot = 3'(k);
            end
        end
    end

    assign n_mask  = r_mask & ~(N'(1) << slot);
    assign emit_go = r_busy && (!r_ov || o_res.ready);
    assign take    = !r_busy || (emit_go && n_mask == '0);
    assign load    = take && i_valid;
    assign o_ready = take;
    assign split   = (r_outcome == rss_pkg::OutSplit);

    always_comb begin
        n_piece = '0;
        if (split) begin
            case (slot)
                rss_pkg::SlotLT: n_piece = {r_cut[rss_pkg::EdgeT], r_cut[rss_pkg::EdgeL],
                                            r_src[rss_pkg::EdgeT], r_src[rss_pkg::EdgeL]};
                rss_pkg::SlotLB: n_piece = {r_src[rss_pkg::EdgeB], r_cut[rss_pkg::EdgeL],
                                            r_cut[rss_pkg::EdgeB], r_src[rss_pkg::EdgeL]};
                rss_pkg::SlotLM: n_piece = {r_mid[rss_pkg::EdgeB], r_cut[rss_pkg::EdgeL],
                                            r_mid[rss_pkg::EdgeT], r_src[rss_pkg::EdgeL]};
                rss_pkg::SlotRT: n_piece = {r_cut[rss_pkg::EdgeT], r_src[rss_pkg::EdgeR],
                                            r_src[rss_pkg::EdgeT], r_cut[rss_pkg::EdgeR]};
                rss_pkg::SlotRB: n_piece = {r_src[rss_pkg::EdgeB], r_src[rss_pkg::EdgeR],
                                            r_cut[rss_pkg::EdgeB], r_cut[rss_pkg::EdgeR]};
                rss_pkg::SlotRM: n_piece = {r_mid[rss_pkg::EdgeB], r_src[rss_pkg::EdgeR],
                                            r_mid[rss_pkg::EdgeT], r_cut[rss_pkg::EdgeR]};
                rss_pkg::SlotTM: n_piece = {r_cut[rss_pkg::EdgeT], r_mid[rss_pkg::EdgeR],
                                            r_src[rss_pkg::EdgeT], r_mid[rss_pkg::EdgeL]};
                rss_pkg::SlotBM: n_piece = {r_src[rss_pkg::EdgeB], r_mid[rss_pkg::EdgeR],
                                            r_cut[rss_pkg::EdgeB], r_mid[rss_pkg::EdgeL]};
                default:         n_piece = '0;
            endcase
        end else if (r_pass) begin
            n_piece = r_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit_go && n_mask == '0) begin
                r_busy <= 1'b0;
            end
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end

        if (load) begin
            r_mask    <= i_plan.mask;
            r_src     <= i_src;
            r_cut     <= i_cut;
            r_mid     <= i_mid;
            r_outcome <= i_plan.outcome;
            r_pass    <= i_plan.pass;
        end else if (emit_go) begin
            r_mask <= n_mask;
        end

        if (emit_go) begin
            r_piece       <= n_piece;
            r_pvalid      <= split || r_pass;
            r_res_outcome <= r_outcome;
            r_last        <= (n_mask == '0);
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.piece_left   = r_piece[rss_pkg::EdgeL];
    assign o_res.piece_top    = r_piece[rss_pkg::EdgeT];
    assign o_res.piece_right  = r_piece[rss_pkg::EdgeR];
    assign o_res.piece_bottom = r_piece[rss_pkg::EdgeB];
    assign o_res.piece_valid  = r_pvalid;
    assign o_res.outcome      = r_res_outcome;
    assign o_res.last_piece   = r_last;

    `RSS_ASSERT_NOW(a_busy_has_work, r_busy, r_mask != '0, "emitter busy with empty mask")
    `RSS_ASSERT_NOW(a_status_is_last, r_ov && !r_pvalid, r_last, "status item not last")
    `RSS_ASSERT_NOW(a_split_has_piece, r_ov && r_res_outcome == rss_pkg::OutSplit,
                    r_pvalid, "split item without piece")
    `RSS_ASSERT_NEXT(a_done_goes_idle, emit_go && n_mask == '0 && !load, !r_busy,
                     "emitter stays busy after final piece")
endmodule

// ===== hdl/rectangle_subtract_split.sv =====
// Throughput: one result item per cycle while o_piece is ready; an item
// occupies the emit stage until its last result is issued (1 to 8 results), so
// items enter back to back when each yields one result. The emit stage,
// walking the piece mask one slot a cycle, sets the rate. Reset (synchronous,
// active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
// Rectangle subtract split: top level
// Removes a cut rectangle from a source rectangle and streams the remaining
// area as up to eight non-overlapping pieces, or one status item.
// ----------------------------------------------------------------------------
module rectangle_subtract_split #(
    parameter int COORD_WIDTH = rss_pkg::CoordWidthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rss_in_if.sink    i_item,
    rss_out_if.source o_piece
);
    // Stage 1 -> stage 2: edges plus all edge comparisons
    logic                        cmp_valid;
    logic                        cmp_ready;
    logic [3:0][COORD_WIDTH-1:0] cmp_src;
    logic [3:0][COORD_WIDTH-1:0] cmp_cut;
    rss_pkg::t_cmp               cmp_flags;

    // Stage 2 -> emit stage: outcome, piece mask and middle band edges
    logic                        plan_valid;
    logic                        plan_ready;
    logic [3:0][COORD_WIDTH-1:0] plan_src;
    logic [3:0][COORD_WIDTH-1:0] plan_cut;
    logic [3:0][COORD_WIDTH-1:0] plan_mid;
    rss_pkg::t_plan              plan_ctl;

    // Compare every source edge against every cut edge it can meet.
    rss_cmp #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (cmp_valid),
        .i_ready (cmp_ready),
        .o_src   (cmp_src),
        .o_cut   (cmp_cut),
        .o_flags (cmp_flags)
    );

    // Resolve the check order into one outcome and the set of pieces to emit.
    rss_plan #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_plan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmp_valid),
        .o_ready (cmp_ready),
        .i_src   (cmp_src),
        .i_cut   (cmp_cut),
        .i_flags (cmp_flags),
        .o_valid (plan_valid),
        .i_ready (plan_ready),
        .o_src   (plan_src),
        .o_cut   (plan_cut),
        .o_mid   (plan_mid),
        .o_plan  (plan_ctl)
    );

    // Emit one piece per cycle while o_piece is ready; hold upstream until the last piece is issued.
    // The output register lets the next item load while a result waits.
    rss_emit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (plan_valid),
        .o_ready (plan_ready),
        .i_src   (plan_src),
        .i_cut   (plan_cut),
        .i_mid   (plan_mid),
        .i_plan  (plan_ctl),
        .o_res   (o_piece)
    );
endmodule
